// File: rtl/core/top_two_pair_invariant_mass_macros.svh
// Assertion macros for the two-shower invariant mass block.
// Included by modules that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef TOP_TWO_PAIR_INVARIANT_MASS_MACROS_SVH
`define TOP_TWO_PAIR_INVARIANT_MASS_MACROS_SVH
`ifndef SYNTHESIS
`define TPIM_ASSERT(name, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tpim check failed");
`define TPIM_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("tpim sequence check failed");
`else
`define TPIM_ASSERT(name, prop)
`define TPIM_ASSERT_NEXT(name, pre, post)
`endif
`endif

// File: rtl/core/tpim_pkg.sv
// Shared types and constants for the two-shower invariant mass block.
// No dependencies; used by the front, queue, back and top modules.
package tpim_pkg;

    localparam int MaxShowersDef = 256;
    localparam int QueueDepth    = 2;
    localparam int OneQ14        = 16384;
    localparam int RootSteps     = 32;
    localparam int DivSteps      = 47;

    typedef struct packed {
        logic             valid;
        logic [23:0]      lead_energy;
        logic [23:0]      sub_energy;
        logic [7:0]       lead_index;
        logic [7:0]       sub_index;
        logic [15:0]      lead_dedx;
        logic [15:0]      sub_dedx;
        logic [2:0][15:0] lead_dir;
        logic [2:0][15:0] sub_dir;
    } t_event;

    typedef struct packed {
        logic        pair_valid;
        logic [23:0] lead_energy;
        logic [23:0] sub_energy;
        logic [7:0]  lead_index;
        logic [7:0]  sub_index;
        logic [15:0] lead_dedx;
        logic [15:0] sub_dedx;
        logic [15:0] cos_opening;
        logic [23:0] pair_mass;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE, S_DOT, S_NORM, S_ROOT_N, S_DIV, S_EMUL, S_EMUL2, S_ROOT_M, S_DONE
    } t_back_state;

endpackage

// File: rtl/core/top_two_pair_invariant_mass.sv
// An item is taken when push is high and full is low; the result of an event follows its last
// shower through 3 dot-product steps, a 32-step root, a 47-step divider and a second root.
// Throughput: one shower per cycle while the two-entry event queue has room; the arithmetic back
// end takes a new event only once the last result is loaded. Reset (i_rst_n low, synchronous)
// clears the tracker, the event queue pointers and the result flag; no clearing pass is needed.
// Depends on tpim_pkg, tpim_front, tpim_queue and tpim_back.
module top_two_pair_invariant_mass import tpim_pkg::*; #(
    parameter int MAX_SHOWERS = MaxShowersDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [23:0] i_shower_energy,
    input  logic [15:0] i_shower_dedx,
    input  logic [15:0] i_dir_x,
    input  logic [15:0] i_dir_y,
    input  logic [15:0] i_dir_z,
    input  logic        i_last_shower,
    output logic        empty,
    input  logic        pop,
    output logic        o_pair_valid,
    output logic [23:0] o_lead_energy,
    output logic [23:0] o_sub_energy,
    output logic [7:0]  o_lead_index,
    output logic [7:0]  o_sub_index,
    output logic [15:0] o_lead_dedx,
    output logic [15:0] o_sub_dedx,
    output logic [15:0] o_cos_opening,
    output logic [23:0] o_pair_mass
);

    // The front end updates the leading pair in the cycle a shower transaction
    // is accepted. A transaction marked last_shower pushes the finished pair into
    // the queue and clears the tracker, so the next event can start at once.
    logic    take;
    logic    evt_push;
    t_event  front_evt;
    logic    q_full, q_avail, q_take;
    t_event  q_evt;
    logic    res_empty;
    t_result res;

    // Input stalls whenever the queue is full; the tracker state itself never
    // needs to wait, but a last shower could otherwise find no room.
    assign full = q_full;
    assign take = push && !q_full;

    tpim_front #(
        .MAX_SHOWERS(MAX_SHOWERS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_shower_energy(i_shower_energy),
        .i_shower_dedx  (i_shower_dedx),
        .i_dir_x        (i_dir_x),
        .i_dir_y        (i_dir_y),
        .i_dir_z        (i_dir_z),
        .i_last_shower  (i_last_shower),
        .o_evt_push     (evt_push),
        .o_evt          (front_evt)
    );

    tpim_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (evt_push),
        .i_evt  (front_evt),
        .i_take (q_take),
        .o_full (q_full),
        .o_avail(q_avail),
        .o_evt  (q_evt)
    );

    // The back end takes one event at a time, computes the cosine and the mass
    // with its shared root and divider, and holds the result until popped.
    tpim_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_avail(q_avail),
        .i_evt  (q_evt),
        .o_take (q_take),
        .i_pop  (pop),
        .o_empty(res_empty),
        .o_res  (res)
    );

    assign empty         = res_empty;
    assign o_pair_valid  = res.pair_valid;
    assign o_lead_energy = res.lead_energy;
    assign o_sub_energy  = res.sub_energy;
    assign o_lead_index  = res.lead_index;
    assign o_sub_index   = res.sub_index;
    assign o_lead_dedx   = res.lead_dedx;
    assign o_sub_dedx    = res.sub_dedx;
    assign o_cos_opening = res.cos_opening;
    assign o_pair_mass   = res.pair_mass;

endmodule

// File: rtl/core/tpim_front.sv
// Front end: tracks the two most energetic showers of the current event.
// Depends on tpim_pkg; hands finished events to the queue.
module tpim_front import tpim_pkg::*; #(
    parameter int MAX_SHOWERS = MaxShowersDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic [23:0] i_shower_energy,
    input  logic [15:0] i_shower_dedx,
    input  logic [15:0] i_dir_x,
    input  logic [15:0] i_dir_y,
    input  logic [15:0] i_dir_z,
    input  logic        i_last_shower,
    output logic        o_evt_push,
    output t_event      o_evt
);

    localparam int CW = $clog2(MAX_SHOWERS + 1);

    logic [CW-1:0]    r_count, n_count;
    t_event           r_st, n_st;
    logic             in_range;
    logic [CW+7:0]    count_ext;
    logic [2:0][15:0] dir;

    assign in_range  = r_count < CW'(MAX_SHOWERS);
    assign count_ext = {8'd0, r_count};
    assign dir       = {i_dir_z, i_dir_y, i_dir_x};

    always_comb begin
        n_st    = r_st;
        n_count = r_count;
        if (in_range) begin
            n_count = r_count + CW'(1);
            if (i_shower_energy > r_st.lead_energy) begin
                n_st.sub_energy  = r_st.lead_energy;
                n_st.sub_index   = r_st.lead_index;
                n_st.sub_dedx    = r_st.lead_dedx;
                n_st.sub_dir     = r_st.lead_dir;
                n_st.lead_energy = i_shower_energy;
                n_st.lead_index  = count_ext[7:0];
                n_st.lead_dedx   = i_shower_dedx;
                n_st.lead_dir    = dir;
            end else if (i_shower_energy > r_st.sub_energy) begin
                n_st.sub_energy  = i_shower_energy;
                n_st.sub_index   = count_ext[7:0];
                n_st.sub_dedx    = i_shower_dedx;
                n_st.sub_dir     = dir;
            end
        end
        n_st.valid = n_count >= CW'(2);
    end

    assign o_evt      = n_st;
    assign o_evt_push = i_take && i_last_shower;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= '0;
            r_count <= '0;
        end else if (i_take) begin
            if (i_last_shower) begin
                r_st    <= '0;
                r_count <= '0;
            end else begin
                r_st    <= n_st;
                r_count <= n_count;
            end
        end
    end

endmodule

// File: rtl/core/tpim_queue.sv
// Two-entry event queue between the front end and the arithmetic back end.
// Depends on tpim_pkg for the event type.
module tpim_queue import tpim_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_event i_evt,
    input  logic   i_take,
    output logic   o_full,
    output logic   o_avail,
    output t_event o_evt
);

    localparam int PW = $clog2(QueueDepth);

    t_event            r_mem [QueueDepth];
    logic [PW-1:0]     r_wr, r_rd;
    logic [PW:0]       r_cnt;

    assign o_full  = r_cnt == (PW+1)'(QueueDepth);
    assign o_avail = r_cnt != '0;
    assign o_evt   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (i_take) begin
                r_rd <= r_rd + PW'(1);
            end
            case ({i_push, i_take})
                2'b10:   r_cnt <= r_cnt + (PW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (PW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: rtl/core/tpim_back.sv
// Back end: per-event cosine and invariant mass with a shared bit-serial root
// and a restoring divider, plus the result register. Depends on tpim_pkg.
`include "top_two_pair_invariant_mass_macros.svh"
module tpim_back import tpim_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_avail,
    input  t_event  i_evt,
    output logic    o_take,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_res
);

    t_back_state r_state, n_state;
    t_event      r_evt;
    logic [1:0]  r_k;
    logic signed [33:0] r_dot;
    logic [31:0] r_na, r_nb;
    logic [63:0] r_x, r_r, r_bit;
    logic [5:0]  r_cnt;
    logic [31:0] r_n;
    logic [46:0] r_num, r_q;
    logic [32:0] r_rem;
    logic [47:0] r_prod;
    logic [15:0] r_cos;
    logic [23:0] r_mass;
    logic        r_full;
    t_result     r_out;

    logic               load_out;
    logic signed [31:0] p_ab, p_aa, p_bb;
    logic [63:0]        root_sum;
    logic               root_ge;
    logic [33:0]        dot_mag;
    logic [32:0]        rem_sh;
    logic               div_ge;
    logic [46:0]        q_next;
    logic [14:0]        q_clamp;
    logic [15:0]        cos_next;
    logic [16:0]        om17;
    logic [63:0]        x_full;

    assign p_ab = $signed(r_evt.lead_dir[r_k]) * $signed(r_evt.sub_dir[r_k]);
    assign p_aa = $signed(r_evt.lead_dir[r_k]) * $signed(r_evt.lead_dir[r_k]);
    assign p_bb = $signed(r_evt.sub_dir[r_k]) * $signed(r_evt.sub_dir[r_k]);

    assign root_sum = r_r + r_bit;
    assign root_ge  = r_x >= root_sum;

    assign dot_mag = r_dot[33] ? 34'(-r_dot) : 34'(r_dot);

    assign rem_sh   = {r_rem[31:0], r_num[46]};
    assign div_ge   = rem_sh >= {1'b0, r_n};
    assign q_next   = {r_q[45:0], div_ge};
    assign q_clamp  = (q_next > 47'(OneQ14)) ? 15'(OneQ14) : q_next[14:0];
    assign cos_next = r_dot[33] ? 16'(-{1'b0, q_clamp}) : {1'b0, q_clamp};

    assign om17   = 17'(OneQ14) - {r_cos[15], r_cos};
    assign x_full = {16'd0, r_prod} * {48'd0, om17[15:0]};

    // Next state and handshake outputs.
    always_comb begin
        n_state  = r_state;
        o_take   = 1'b0;
        load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_avail) begin
                    o_take  = 1'b1;
                    n_state = i_evt.valid ? S_DOT : S_DONE;
                end
            end
            S_DOT: begin
                if (r_k == 2'd2) begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                n_state = (r_na == '0 || r_nb == '0) ? S_DONE : S_ROOT_N;
            end
            S_ROOT_N: begin
                if (r_cnt == 6'(RootSteps - 1)) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == 6'(DivSteps - 1)) begin
                    n_state = S_EMUL;
                end
            end
            S_EMUL:  n_state = S_EMUL2;
            S_EMUL2: n_state = S_ROOT_M;
            S_ROOT_M: begin
                if (r_cnt == 6'(RootSteps - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_full || i_pop) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_evt  <= i_evt;
                r_k    <= '0;
                r_dot  <= '0;
                r_na   <= '0;
                r_nb   <= '0;
                r_cos  <= '0;
                r_mass <= '0;
            end
            S_DOT: begin
                r_k   <= r_k + 2'd1;
                r_dot <= r_dot + 34'(p_ab);
                r_na  <= r_na + $unsigned(p_aa);
                r_nb  <= r_nb + $unsigned(p_bb);
            end
            S_NORM: begin
                r_x   <= {32'd0, r_na} * {32'd0, r_nb};
                r_r   <= '0;
                r_bit <= 64'd1 << 62;
                r_cnt <= '0;
            end
            S_ROOT_N, S_ROOT_M: begin
                if (root_ge) begin
                    r_x <= r_x - root_sum;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 6'd1;
                if (r_state == S_ROOT_N && r_cnt == 6'(RootSteps - 1)) begin
                    r_n   <= root_ge ? 32'((r_r >> 1) + r_bit) : 32'(r_r >> 1);
                    r_cnt <= '0;
                    r_rem <= '0;
                    r_q   <= '0;
                end
            end
            S_DIV: begin
                r_cnt <= r_cnt + 6'd1;
                r_q   <= q_next;
                r_num <= {r_num[45:0], 1'b0};
                r_rem <= div_ge ? rem_sh - {1'b0, r_n} : rem_sh;
                if (r_cnt == 6'(DivSteps - 1)) begin
                    r_cos <= cos_next;
                end
            end
            S_EMUL: begin
                r_prod <= {24'd0, r_evt.lead_energy} * {24'd0, r_evt.sub_energy};
            end
            S_EMUL2: begin
                r_x   <= {13'd0, x_full[63:13]};
                r_r   <= '0;
                r_bit <= 64'd1 << 62;
                r_cnt <= '0;
            end
            default: begin
            end
        endcase
        // The divider numerator is set up as the first root finishes.
        if (r_state == S_ROOT_N && r_cnt == 6'(RootSteps - 1)) begin
            r_num <= 47'({dot_mag[31:0], 14'd0})
                   + 47'((root_ge ? 32'((r_r >> 1) + r_bit) : 32'(r_r >> 1)) >> 1);
        end
        if (r_state == S_ROOT_M && r_cnt == 6'(RootSteps - 1)) begin
            r_mass <= (root_ge ? ((r_r >> 1) + r_bit) : (r_r >> 1)) > 64'hFF_FFFF
                    ? 24'hFF_FFFF
                    : 24'(root_ge ? ((r_r >> 1) + r_bit) : (r_r >> 1));
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            if (r_evt.valid) begin
                r_out.pair_valid  <= 1'b1;
                r_out.lead_energy <= r_evt.lead_energy;
                r_out.sub_energy  <= r_evt.sub_energy;
                r_out.lead_index  <= r_evt.lead_index;
                r_out.sub_index   <= r_evt.sub_index;
                r_out.lead_dedx   <= r_evt.lead_dedx;
                r_out.sub_dedx    <= r_evt.sub_dedx;
                r_out.cos_opening <= r_cos;
                r_out.pair_mass   <= r_mass;
            end else begin
                r_out <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (load_out) begin
            r_full <= 1'b1;
        end else if (i_pop) begin
            r_full <= 1'b0;
        end
    end

    assign o_empty = !r_full;
    assign o_res   = r_out;

    `TPIM_ASSERT(a_cos_range, r_full |-> ($signed(r_out.cos_opening) >= -16'sd16384 && $signed(r_out.cos_opening) <= 16'sd16384))
    `TPIM_ASSERT(a_invalid_zero, (r_full && !r_out.pair_valid) |-> (r_out.pair_mass == '0 && r_out.cos_opening == '0 && r_out.lead_energy == '0))
    `TPIM_ASSERT_NEXT(a_result_held, r_full && !i_pop, r_full && $stable(r_out))
    `TPIM_ASSERT_NEXT(a_take_starts, o_take, r_state == S_DOT || r_state == S_DONE)

endmodule
